// ===== rtl/urlqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package urlqs_pkg;

  // Default saturation limit for byte offsets.
  localparam int unsigned MAX_LEN = 65536;

  // Width of the offset fields on the result channel.
  localparam int unsigned OFF_W = 17;

  // Delimiter characters.
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'

  // One input byte as it is handed from the input register to the parser.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_url;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/urlqs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface urlqs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_url;

  modport source (output valid, output char_byte, output end_of_url, input ready);
  modport sink (input valid, input char_byte, input end_of_url, output ready);
endinterface

`default_nettype wire

// ===== rtl/urlqs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface urlqs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           token_valid;
  logic [urlqs_pkg::OFF_W-1:0]    param_start;
  logic [urlqs_pkg::OFF_W-1:0]    param_end;
  logic                           string_end;

  modport source (output valid, output token_valid, output param_start,
                  output param_end, output string_end, input ready);
  modport sink (input valid, input token_valid, input param_start,
                input param_end, input string_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/urlqs_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urlqs_parse #(
  parameter int unsigned MaxLen = urlqs_pkg::MAX_LEN,
  parameter int unsigned PosW   = $clog2(MaxLen + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire urlqs_pkg::step_t item_i,
  output logic                  emit_o,
  output logic [PosW-1:0]       start_o,
  output logic [PosW-1:0]       end_o
);

  typedef enum logic [1:0] {
    PH_SEEK  = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   origin_q, origin_d;
  logic [PosW-1:0]   after;
  logic              last;
  logic              is_query, is_close, is_equal;

  assign last     = item_i.end_of_url;
  assign is_query = (item_i.char_byte == urlqs_pkg::CH_QUERY);
  assign is_equal = (item_i.char_byte == urlqs_pkg::CH_EQUAL);
  assign is_close = (item_i.char_byte == urlqs_pkg::CH_AMP) ||
                    (item_i.char_byte == urlqs_pkg::CH_HASH);

  // Offsets stop counting once they reach the limit.
  assign after = (pos_q == PosW'(MaxLen)) ? pos_q : pos_q + PosW'(1);

  always_comb begin
    phase_d  = phase_q;
    origin_d = origin_q;
    emit_o   = 1'b0;
    start_o  = '0;
    end_o    = '0;

    unique case (phase_q)
      PH_NAME: begin
        if (is_query) begin
          origin_d = after;
        end else if (is_close) begin
          emit_o   = 1'b1;
          start_o  = origin_q;
          end_o    = pos_q;
          origin_d = after;
        end else if (is_equal) begin
          if (last) begin
            emit_o  = 1'b1;
            start_o = origin_q;
            end_o   = after;
          end else begin
            phase_d = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (is_close) begin
          emit_o   = 1'b1;
          start_o  = origin_q;
          end_o    = pos_q;
          origin_d = after;
          phase_d  = PH_NAME;
        end else if (last) begin
          emit_o  = 1'b1;
          start_o = origin_q;
          end_o   = after;
        end
      end
      default: begin
        // Seeking the start of the query; the unused code behaves the same.
        if ((is_query || (item_i.char_byte == urlqs_pkg::CH_HASH)) && !last) begin
          phase_d  = PH_NAME;
          origin_d = after;
        end
      end
    endcase

    pos_d = after;
    if (last) begin
      phase_d  = PH_SEEK;
      pos_d    = '0;
      origin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEEK;
      pos_q    <= '0;
      origin_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      origin_q <= origin_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/url_query_parameter_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// URL query parameter splitter. Bytes of a URL enter on req_i, one per
// transaction, with end_of_url set on the last byte of each string. For each
// query parameter closed by '&', '#' or, once its '=' is reached, the end of
// the string, the block returns a transaction on rsp_o carrying the start
// offset and the exclusive end offset of the token, given on the byte that
// closes it; the last byte of a string always returns a transaction with
// string_end set, and token_valid tells whether it also carries a token.
// Bytes that close nothing return no transaction. The block takes one byte
// per clock cycle unless the result side stalls: a byte is captured in an
// input register, parsed against the phase and offset registers, and its
// result is written to the output register. The parser update, which must
// see the state left by the previous byte, sets that rate. While the output
// register holds an unclaimed result, one more byte can still be taken into
// the input register; after that a byte enters only in a cycle in which the
// held result is taken. Offsets saturate at MaxLen; their low 17 bits are sent.
module url_query_parameter_splitter #(
  parameter int unsigned MaxLen = urlqs_pkg::MAX_LEN
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  urlqs_in_if.sink   req_i,
  urlqs_out_if.source rsp_o
);

  localparam int unsigned PosW = $clog2(MaxLen + 1);
  localparam int unsigned ExtW = PosW + urlqs_pkg::OFF_W;

  // Input register.
  logic              in_vld_q;
  urlqs_pkg::step_t  in_q;

  // Output register.
  logic                          out_vld_q;
  logic                          tok_q;
  logic                          send_q;
  logic [urlqs_pkg::OFF_W-1:0]   start_q;
  logic [urlqs_pkg::OFF_W-1:0]   end_q;

  logic              adv;
  logic              step;
  logic              emit;
  logic [PosW-1:0]   start_pos, end_pos;
  logic [ExtW-1:0]   start_ext, end_ext;

  // The output register can load whenever it is empty or its result is
  // being taken in this cycle. The parser advances only then.
  assign adv  = !out_vld_q || rsp_o.ready;
  assign step = in_vld_q && adv;

  // A new byte can enter whenever the held byte moves on, or none is held.
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.char_byte  <= req_i.char_byte;
      in_q.end_of_url <= req_i.end_of_url;
    end
  end

  urlqs_parse #(
    .MaxLen (MaxLen),
    .PosW   (PosW)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .emit_o  (emit),
    .start_o (start_pos),
    .end_o   (end_pos)
  );

  // Offsets are reported as their low bits, whatever the internal width.
  assign start_ext = ExtW'(start_pos);
  assign end_ext   = ExtW'(end_pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q && (emit || in_q.end_of_url);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      tok_q   <= emit;
      send_q  <= in_q.end_of_url;
      start_q <= start_ext[urlqs_pkg::OFF_W-1:0];
      end_q   <= end_ext[urlqs_pkg::OFF_W-1:0];
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.token_valid = tok_q;
  assign rsp_o.param_start = start_q;
  assign rsp_o.param_end   = end_q;
  assign rsp_o.string_end  = send_q;

endmodule

`default_nettype wire

// ===== tb/sv/urlqs_token_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the splitter, tracks the parse of each URL on its
// own and compares every result transaction against the oldest expected token.
module urlqs_token_checker #(
  parameter int unsigned MaxLen = urlqs_pkg::MAX_LEN
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  urlqs_in_if        req_i,
  urlqs_out_if       rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import urlqs_pkg::*;

  typedef enum logic [1:0] {
    SEEK_QUERY = 2'd0,
    IN_NAME    = 2'd1,
    IN_VALUE   = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic             token_valid;
    logic [OFF_W-1:0] param_start;
    logic [OFF_W-1:0] param_end;
    logic             string_end;
  } token_t;

  parse_phase_e phase_q;
  int unsigned  byte_pos_q;
  int unsigned  origin_q;
  token_t       expected_tokens[$];

  task automatic report(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  // Advances the parse by one byte and queues the result that byte produces, if any.
  task automatic parse_byte(input logic [7:0] ch, input logic last);
    int unsigned here;
    int unsigned after;
    logic        emit;
    int unsigned tok_start;
    int unsigned tok_end;
    token_t      tok;
    here      = byte_pos_q;
    after     = (here + 1 > MaxLen) ? MaxLen : here + 1;
    emit      = 1'b0;
    tok_start = 0;
    tok_end   = 0;
    case (phase_q)
      IN_NAME: begin
        if (ch == CH_QUERY) begin
          origin_q = after;
        end else if (ch == CH_AMP || ch == CH_HASH) begin
          emit      = 1'b1;
          tok_start = origin_q;
          tok_end   = here;
          origin_q  = after;
        end else if (ch == CH_EQUAL) begin
          if (last) begin
            emit      = 1'b1;
            tok_start = origin_q;
            tok_end   = after;
          end else begin
            phase_q = IN_VALUE;
          end
        end
      end
      IN_VALUE: begin
        if (ch == CH_AMP || ch == CH_HASH) begin
          emit      = 1'b1;
          tok_start = origin_q;
          tok_end   = here;
          origin_q  = after;
          phase_q   = IN_NAME;
        end else if (last) begin
          emit      = 1'b1;
          tok_start = origin_q;
          tok_end   = after;
        end
      end
      default: begin
        if ((ch == CH_QUERY || ch == CH_HASH) && !last) begin
          phase_q  = IN_NAME;
          origin_q = after;
        end
      end
    endcase
    byte_pos_q = after;
    if (last) begin
      phase_q    = SEEK_QUERY;
      byte_pos_q = 0;
      origin_q   = 0;
    end
    if (emit || last) begin
      tok.token_valid = emit;
      tok.param_start = emit ? tok_start[OFF_W-1:0] : '0;
      tok.param_end   = emit ? tok_end[OFF_W-1:0] : '0;
      tok.string_end  = last;
      expected_tokens.push_back(tok);
    end
  endtask

  // All channel signals change only at rising edges, so a handshake seen at
  // the falling edge is the one that completes at the next rising edge.
  always @(negedge clk_i) begin
    token_t want;
    if (!rst_ni) begin
      phase_q    = SEEK_QUERY;
      byte_pos_q = 0;
      origin_q   = 0;
      expected_tokens.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        parse_byte(req_i.char_byte, req_i.end_of_url);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected result tv=%0b start=%0d end=%0d se=%0b",
                           rsp_i.token_valid, rsp_i.param_start, rsp_i.param_end,
                           rsp_i.string_end));
        end else begin
          want = expected_tokens.pop_front();
          if (rsp_i.token_valid !== want.token_valid) begin
            report($sformatf("token_valid got %0b expected %0b",
                             rsp_i.token_valid, want.token_valid));
          end
          if (rsp_i.param_start !== want.param_start) begin
            report($sformatf("param_start got %0d expected %0d",
                             rsp_i.param_start, want.param_start));
          end
          if (rsp_i.param_end !== want.param_end) begin
            report($sformatf("param_end got %0d expected %0d",
                             rsp_i.param_end, want.param_end));
          end
          if (rsp_i.string_end !== want.string_end) begin
            report($sformatf("string_end got %0b expected %0b",
                             rsp_i.string_end, want.string_end));
          end
        end
      end
    end
    pending_o = expected_tokens.size();
  end

endmodule

// ===== tb/sv/tb_url_query_parameter_splitter.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the URL query parameter splitter. The checker
// instance next to the block does all prediction and comparison; this module
// only produces byte streams, toggles the result-side ready, and decides
// pass or fail from the checker's error and pending counts.
module tb_url_query_parameter_splitter;
  import urlqs_pkg::*;

  // Number of random bytes to send; the last stretch of them runs without
  // any idling on either side.
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned QuietBytes  = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // When set, neither the sender nor the receiver inserts idle cycles.
  bit quiet = 1'b0;

  int unsigned fail_count;
  int unsigned pending_tokens;
  int unsigned bytes_sent;

  // The URL currently being assembled for transmission.
  logic [7:0] url_bytes[$];

  always #2 clk_i = ~clk_i;

  urlqs_in_if  req_if ();
  urlqs_out_if rsp_if ();

  url_query_parameter_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  urlqs_token_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_tokens)
  );

  // Any byte that is not one of the four delimiters.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_QUERY || c == CH_HASH || c == CH_EQUAL || c == CH_AMP);
    return c;
  endfunction

  // Noise bytes lean heavily on the delimiters so that broken sequences
  // still hit the interesting phase transitions.
  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 3))
      0: return CH_QUERY;
      1: return CH_HASH;
      2: return CH_EQUAL;
      default: return CH_AMP;
    endcase
  endfunction

  // Parameter separator: mostly '&', sometimes '#', and now and then a '?'
  // which, instead of closing the parameter, restarts a name or joins a value.
  function automatic logic [7:0] separator_char();
    case ($urandom_range(0, 9))
      0, 1: return CH_HASH;
      2: return CH_QUERY;
      default: return CH_AMP;
    endcase
  endfunction

  // Sends one byte. The handshake is sampled at the falling edge, where all
  // channel signals have settled, and completes at the following rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic taken;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.char_byte  <= b;
    req_if.end_of_url <= last;
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
  endtask

  // Sends the assembled URL with the end marker on its final byte.
  task automatic send_url();
    for (int i = 0; i < url_bytes.size(); i++) begin
      send_byte(url_bytes[i], i == url_bytes.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    url_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      url_bytes.push_back(s[i]);
    end
    send_url();
  endtask

  // Holds the sender off until every expected result has been delivered.
  task automatic drain();
    req_if.valid <= 1'b0;
    wait (pending_tokens == 0);
    @(posedge clk_i);
  endtask

  // Builds one random URL. Most are well formed: an optional path, a query
  // mark or fragment mark, then a handful of name or name=value parameters with random
  // content. The rest are short runs of delimiter-heavy noise.
  task automatic build_query(input bit noise);
    int unsigned n_params;
    url_bytes.delete();
    if (noise) begin
      repeat ($urandom_range(1, 12)) url_bytes.push_back(noise_char());
    end else begin
      repeat ($urandom_range(0, 3)) url_bytes.push_back(plain_char());
      url_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_HASH : CH_QUERY);
      n_params = $urandom_range(0, 4);
      for (int p = 0; p < n_params; p++) begin
        if (p > 0) begin
          url_bytes.push_back(separator_char());
        end
        repeat ($urandom_range(0, 4)) url_bytes.push_back(plain_char());
        if ($urandom_range(0, 3) != 0) begin
          url_bytes.push_back(CH_EQUAL);
          // A value may itself contain '=' or '?', which do not close it.
          repeat ($urandom_range(0, 4)) begin
            url_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                (($urandom_range(0, 1) == 0) ? CH_EQUAL : CH_QUERY) :
                                plain_char());
          end
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        url_bytes.push_back(separator_char());
      end
    end
  endtask

  // Result-side ready: random stall bursts between random stretches of
  // readiness. Each loop pass starts on a fresh rising edge, so ready gets a
  // single assignment per step.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    req_if.valid      = 1'b0;
    req_if.char_byte  = '0;
    req_if.end_of_url = 1'b0;
    bytes_sent        = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings. A one-byte string with the top byte value, lone query
    // and fragment marks on the last byte, an '=' that ends the string, a
    // name restarted by '?', a name-only token, a value closed by '#' on the
    // last byte, a value closed by the end of the string, a dropped trailing
    // name, an '&' ignored while seeking, and an empty value closed by '&'.
    url_bytes.delete();
    url_bytes.push_back(8'hFF);
    send_url();
    send_text("?");
    send_text("#");
    send_text("#a=");
    send_text("?a?b&c=d#");
    send_text("?x=y");
    send_text("?n");
    send_text("&?=&");
    drain();

    // Random part: one string in five is noise.
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      if (bytes_sent >= RandomBytes - QuietBytes) begin
        quiet = 1'b1;
      end
      build_query($urandom_range(0, 4) == 0);
      send_url();
    end
    req_if.valid <= 1'b0;

    // Let the last results drain, then keep watching the pipeline for anything
    // it should not produce.
    wait (pending_tokens == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_tokens == 0) begin
      $display("url_query_parameter_splitter test passed");
    end else begin
      $display("url_query_parameter_splitter test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("url_query_parameter_splitter test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/urlqs_pkg.sv
rtl/urlqs_in_if.sv
rtl/urlqs_out_if.sv
rtl/urlqs_parse.sv
rtl/url_query_parameter_splitter.sv
tb/sv/urlqs_token_checker.sv
tb/sv/tb_url_query_parameter_splitter.sv
